>>> rtl/phps_pkg.sv
// ---------------------------------------------------------------------------
// phps_pkg: shared types and constants of the heading PID steering block
// Fixed-point constants, operation codes, register indexes and the CORDIC
// arctangent table used by the sequencer and the CORDIC unit.
// ---------------------------------------------------------------------------
`default_nettype none

package phps_pkg;

    localparam int POS_W = 24;
    localparam int ANG_W = 16;
    localparam int DIFF_W = POS_W + 1;
    localparam int MUL_W = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;
    localparam int ATAN_IDX_W = 5;
    localparam int Z_W = 26;
    localparam int CX_W = 44;

    localparam logic signed [ANG_W:0] PI_Q13 = 17'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [Z_W-1:0] PI_Q20 = 26'sd3294199;
    localparam logic [12:0] WEIGHT_ONE = 13'd4096;

    typedef logic [1:0] op_t;
    localparam op_t OP_FWD = 2'd0;
    localparam op_t OP_REV = 2'd1;
    localparam op_t OP_TRAJ = 2'd2;
    localparam op_t OP_CLR = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GAIN_P = 3'd0;
    localparam cfg_idx_t CFG_GAIN_I = 3'd1;
    localparam cfg_idx_t CFG_GAIN_D = 3'd2;
    localparam cfg_idx_t CFG_GOAL_WEIGHT = 3'd3;
    localparam cfg_idx_t CFG_NEAR_DIST = 3'd4;
    localparam cfg_idx_t CFG_SUM_LIMIT = 3'd5;
    localparam cfg_idx_t CFG_OUT_LIMIT = 3'd6;

    // Arctangent of 2^-i in Q3.20.
    function automatic logic [19:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
        logic [19:0] r;
        unique case (idx)
            5'd0: r = 20'd823550;
            5'd1: r = 20'd486170;
            5'd2: r = 20'd256879;
            5'd3: r = 20'd130396;
            5'd4: r = 20'd65451;
            5'd5: r = 20'd32757;
            5'd6: r = 20'd16383;
            5'd7: r = 20'd8192;
            5'd8: r = 20'd4096;
            5'd9: r = 20'd2048;
            5'd10: r = 20'd1024;
            5'd11: r = 20'd512;
            5'd12: r = 20'd256;
            5'd13: r = 20'd128;
            5'd14: r = 20'd64;
            5'd15: r = 20'd32;
            5'd16: r = 20'd16;
            5'd17: r = 20'd8;
            5'd18: r = 20'd4;
            5'd19: r = 20'd2;
            5'd20: r = 20'd1;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/phps_mul.sv
// ---------------------------------------------------------------------------
// phps_mul: shared signed multiplier
// One 25 by 25 bit signed product per cycle, registered at the output.
// ---------------------------------------------------------------------------
`default_nettype none

module phps_mul
    import phps_pkg::*;
(
    input  wire                        aclk,
    input  wire signed [MUL_W-1:0]     a,
    input  wire signed [MUL_W-1:0]     b,
    output logic signed [PROD_W-1:0]   p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

>>> rtl/phps_cordic.sv
// ---------------------------------------------------------------------------
// phps_cordic: iterative vectoring CORDIC for atan2
// One rotation per cycle on a Q3.20 angle, rounded to Q3.13 at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module phps_cordic
    import phps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        start,
    input  wire signed [DIFF_W-1:0]    y_in,
    input  wire signed [DIFF_W-1:0]    x_in,
    output logic                       done_reg,
    output logic signed [ANG_W-1:0]    angle_reg
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

    logic                     busy_reg;
    logic                     zero_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [CX_W-1:0]   x_reg;
    logic signed [CX_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;

    logic signed [CX_W-1:0]   xs;
    logic signed [CX_W-1:0]   ys;
    logic signed [CX_W-1:0]   xsh;
    logic signed [CX_W-1:0]   ysh;
    logic signed [Z_W-1:0]    step_ang;
    logic signed [Z_W-1:0]    z_rnd;
    logic signed [Z_W-8:0]    z_q13;

    assign xs = {{(CX_W-DIFF_W-16){x_in[DIFF_W-1]}}, x_in, 16'd0};
    assign ys = {{(CX_W-DIFF_W-16){y_in[DIFF_W-1]}}, y_in, 16'd0};
    assign xsh = x_reg >>> cnt_reg;
    assign ysh = y_reg >>> cnt_reg;
    assign step_ang = $signed({{(Z_W-20){1'b0}}, atan_q20(ATAN_IDX_W'(cnt_reg))});
    assign z_rnd = z_reg + Z_W'(64);
    assign z_q13 = z_rnd[Z_W-1:7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                zero_reg <= (x_in == '0) && (y_in == '0);
                if (x_in < 0) begin
                    x_reg <= -xs;
                    y_reg <= -ys;
                    z_reg <= (y_in >= 0) ? PI_Q20 : -PI_Q20;
                end else begin
                    x_reg <= xs;
                    y_reg <= ys;
                    z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (zero_reg) begin
                        angle_reg <= '0;
                    end else if (z_q13 > PI_Q13) begin
                        angle_reg <= ANG_W'(PI_Q13);
                    end else if (z_q13 < -PI_Q13) begin
                        angle_reg <= ANG_W'(-PI_Q13);
                    end else begin
                        angle_reg <= ANG_W'(z_q13);
                    end
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ysh;
                        y_reg <= y_reg - xsh;
                        z_reg <= z_reg + step_ang;
                    end else begin
                        x_reg <= x_reg - ysh;
                        y_reg <= y_reg + xsh;
                        z_reg <= z_reg - step_ang;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pose_heading_pid_steering.sv
// ---------------------------------------------------------------------------
// pose_heading_pid_steering: heading PID steering controller
// Turns a car pose and a goal pose into a saturated PID steering command.
// ---------------------------------------------------------------------------
// Flow: one item at a time; s_tready is high only in the idle state, so
// the next item is taken once the last has loaded its result, and a
// result waiting on m_tready holds the sequencer in its output states.
// Reset: aresetn is synchronous and active low; it restores the register
// defaults and zeroes the stored error and the error sum.
`default_nettype none

module pose_heading_pid_steering
    import phps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // Configuration write port.
    input  wire                     cfg_we,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_wdata,
    // Input items.
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // car_x, car_y, car_heading, goal_x, goal_y, goal_heading
    input  wire [127:0]             s_tdata,
    // operation
    input  wire [1:0]               s_tuser,
    // Result items.
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // steering, heading_error
    output logic [31:0]             m_tdata
);

    // Sequencer states. Each multiply state issues one product; the state
    // after it consumes it from the multiplier register.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CST   = 4'd1;
    localparam logic [3:0] S_CWAIT = 4'd2;
    localparam logic [3:0] S_DXX   = 4'd3;
    localparam logic [3:0] S_DYY   = 4'd4;
    localparam logic [3:0] S_NN    = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_BL1   = 4'd7;
    localparam logic [3:0] S_BL2   = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_TOT   = 4'd10;
    localparam logic [3:0] S_P     = 4'd11;
    localparam logic [3:0] S_I     = 4'd12;
    localparam logic [3:0] S_D     = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_CLR   = 4'd15;

    // Configuration registers.
    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [12:0]        goal_weight_reg;
    logic [22:0]        near_distance_reg, sum_limit_reg;
    logic [14:0]        output_limit_reg;

    // Controller state.
    logic signed [ANG_W-1:0]  last_error_reg;
    logic signed [POS_W-1:0]  total_reg;

    // Item registers.
    logic [3:0]               state_reg;
    op_t                      op_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [ANG_W-1:0]  ch_reg, gh_reg, brg_reg, err_reg;
    logic signed [ANG_W:0]    diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Result register.
    logic                     m_valid_reg;
    logic signed [ANG_W-1:0]  steer_reg, herr_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, acc_sum;
    logic                     cordic_done;
    logic signed [ANG_W-1:0]  cordic_angle;
    logic [12:0]              w_eff;
    logic signed [17:0]       err_raw, err_wrap;
    logic signed [POS_W:0]    total_sum, total_lim;
    logic signed [ACC_W-13:0] ctrl_raw;
    logic signed [ANG_W-1:0]  ctrl_sat;
    logic                     accept, out_free, result_load;

    logic signed [DIFF_W-1:0] in_dx, in_dy;

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign result_load = ((state_reg == S_OUT) || (state_reg == S_CLR)) && out_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {herr_reg, steer_reg};

    // Goal minus car, or car minus goal when steering in reverse.
    always_comb begin
        if (s_tuser == OP_REV) begin
            in_dx = DIFF_W'($signed(s_tdata[23:0])) - DIFF_W'($signed(s_tdata[87:64]));
            in_dy = DIFF_W'($signed(s_tdata[47:24])) - DIFF_W'($signed(s_tdata[111:88]));
        end else begin
            in_dx = DIFF_W'($signed(s_tdata[87:64])) - DIFF_W'($signed(s_tdata[23:0]));
            in_dy = DIFF_W'($signed(s_tdata[111:88])) - DIFF_W'($signed(s_tdata[47:24]));
        end
    end

    assign w_eff = (goal_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : goal_weight_reg;

    phps_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == S_CST),
        .y_in      (dy_reg),
        .x_in      (dx_reg),
        .done_reg  (cordic_done),
        .angle_reg (cordic_angle)
    );

    // Operand selection for the shared multiplier. The output state keeps
    // the derivative operands so its product stays put while it waits.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DXX: begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            S_DYY: begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            S_NN: begin
                mul_a = {2'b00, near_distance_reg};
                mul_b = {2'b00, near_distance_reg};
            end
            S_CMP: begin
                mul_a = {12'd0, w_eff};
                mul_b = MUL_W'(brg_reg);
            end
            S_BL1: begin
                mul_a = {12'd0, WEIGHT_ONE - w_eff};
                mul_b = MUL_W'(gh_reg);
            end
            S_P: begin
                mul_a = MUL_W'(gain_p_reg);
                mul_b = MUL_W'(err_reg);
            end
            S_I: begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = MUL_W'(total_reg);
            end
            S_D, S_OUT: begin
                mul_a = MUL_W'(gain_d_reg);
                mul_b = MUL_W'(diff_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    phps_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    assign prod_ext = ACC_W'(prod);
    assign acc_sum = acc_reg + prod_ext + ACC_W'(2048);

    // Heading error, wrapped once into plus or minus pi, then saturated.
    assign err_raw = 18'(brg_reg) - 18'(ch_reg);
    always_comb begin
        if (err_raw < -18'(PI_Q13)) begin
            err_wrap = err_raw + TWO_PI_Q13;
        end else if (err_raw > 18'(PI_Q13)) begin
            err_wrap = err_raw - TWO_PI_Q13;
        end else begin
            err_wrap = err_raw;
        end
    end

    // Error sum: trajectory mode clamps to the configured bound, point
    // modes only at the width of the register.
    assign total_sum = (POS_W+1)'(total_reg) + (POS_W+1)'(err_reg);
    always_comb begin
        if (op_reg == OP_TRAJ) begin
            if (total_sum > $signed({2'b00, sum_limit_reg})) begin
                total_lim = $signed({2'b00, sum_limit_reg});
            end else if (total_sum < -$signed({2'b00, sum_limit_reg})) begin
                total_lim = -$signed({2'b00, sum_limit_reg});
            end else begin
                total_lim = total_sum;
            end
        end else begin
            if (total_sum > (POS_W+1)'(25'sd8388607)) begin
                total_lim = 25'sd8388607;
            end else if (total_sum < -(POS_W+1)'(25'sd8388608)) begin
                total_lim = -25'sd8388608;
            end else begin
                total_lim = total_sum;
            end
        end
    end

    // Final command: round, clamp to the output limit, negate in reverse.
    assign ctrl_raw = acc_sum[ACC_W-1:12];
    always_comb begin
        if (ctrl_raw > $signed({1'b0, output_limit_reg})) begin
            ctrl_sat = $signed({1'b0, output_limit_reg});
        end else if (ctrl_raw < -$signed({1'b0, output_limit_reg})) begin
            ctrl_sat = -$signed({1'b0, output_limit_reg});
        end else begin
            ctrl_sat = ANG_W'(ctrl_raw);
        end
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg        <= 16'sd3277;
            gain_i_reg        <= 16'sd0;
            gain_d_reg        <= -16'sd1434;
            goal_weight_reg   <= 13'd4096;
            near_distance_reg <= 23'd4915;
            sum_limit_reg     <= 23'd81920;
            output_limit_reg  <= 15'd6554;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_P:      gain_p_reg <= cfg_wdata[15:0];
                CFG_GAIN_I:      gain_i_reg <= cfg_wdata[15:0];
                CFG_GAIN_D:      gain_d_reg <= cfg_wdata[15:0];
                CFG_GOAL_WEIGHT: goal_weight_reg <= cfg_wdata[12:0];
                CFG_NEAR_DIST:   near_distance_reg <= cfg_wdata;
                CFG_SUM_LIMIT:   sum_limit_reg <= cfg_wdata;
                CFG_OUT_LIMIT:   output_limit_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            last_error_reg <= '0;
            total_reg      <= '0;
        end else begin
            if (m_valid_reg && m_tready && !result_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg <= s_tuser;
                        dx_reg <= in_dx;
                        dy_reg <= in_dy;
                        ch_reg <= s_tdata[63:48];
                        gh_reg <= s_tdata[127:112];
                        if (s_tuser == OP_CLR) begin
                            last_error_reg <= '0;
                            total_reg      <= '0;
                            state_reg      <= S_CLR;
                        end else begin
                            state_reg <= S_CST;
                        end
                    end
                end
                S_CST: state_reg <= S_CWAIT;
                S_CWAIT: begin
                    if (cordic_done) begin
                        brg_reg   <= cordic_angle;
                        state_reg <= (op_reg == OP_TRAJ) ? S_DXX : S_ERR;
                    end
                end
                S_DXX: state_reg <= S_DYY;
                S_DYY: begin
                    acc_reg   <= prod_ext;
                    state_reg <= S_NN;
                end
                S_NN: begin
                    acc_reg   <= acc_reg + prod_ext;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    // acc_reg holds the squared distance, prod the squared limit.
                    state_reg <= (acc_reg <= prod_ext) ? S_BL1 : S_ERR;
                end
                S_BL1: begin
                    acc_reg   <= prod_ext;
                    state_reg <= S_BL2;
                end
                S_BL2: begin
                    brg_reg   <= ANG_W'(acc_sum[ACC_W-1:12]);
                    state_reg <= S_ERR;
                end
                S_ERR: begin
                    if (err_wrap > 18'sd32767) begin
                        err_reg <= 16'sh7FFF;
                    end else if (err_wrap < -18'sd32768) begin
                        err_reg <= 16'sh8000;
                    end else begin
                        err_reg <= ANG_W'(err_wrap);
                    end
                    state_reg <= S_TOT;
                end
                S_TOT: begin
                    diff_reg       <= (ANG_W+1)'(err_reg) - (ANG_W+1)'(last_error_reg);
                    last_error_reg <= err_reg;
                    total_reg      <= POS_W'(total_lim);
                    state_reg      <= S_P;
                end
                S_P: state_reg <= S_I;
                S_I: begin
                    acc_reg   <= prod_ext;
                    state_reg <= S_D;
                end
                S_D: begin
                    acc_reg   <= acc_reg + prod_ext;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // The last product stays in the multiplier register
                    // while the result register drains.
                    if (out_free) begin
                        steer_reg   <= (op_reg == OP_REV) ? -ctrl_sat : ctrl_sat;
                        herr_reg    <= err_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_CLR: begin
                    if (out_free) begin
                        steer_reg   <= '0;
                        herr_reg    <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == OP_CLR) |=> (last_error_reg == '0 && total_reg == '0))
        else $error("clear item did not zero the controller state");

    a_traj_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TOT && op_reg == OP_TRAJ) |=>
        (total_reg <= $signed({1'b0, sum_limit_reg}) &&
         total_reg >= -$signed({1'b0, sum_limit_reg})))
        else $error("trajectory error sum left its clamp");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT || $past(state_reg) == S_CLR))
        else $error("result raised outside the output states");

    a_blend_only_traj: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DXX) |-> (op_reg == OP_TRAJ))
        else $error("distance test entered outside trajectory mode");
`endif

endmodule

`default_nettype wire

>>> test/pose_heading_pid_steering_tb.sv
// ---------------------------------------------------------------------------
// pose_heading_pid_steering_tb: self-checking testbench of the steering block
// Drives directed and random pose items through the stream ports, predicts
// each steering result with an independent fixed-point CORDIC and PID model,
// and compares every result field by field in order of arrival.
// ---------------------------------------------------------------------------
`default_nettype none

module pose_heading_pid_steering_tb;
    import phps_pkg::*;

    localparam int ITEM_COUNT = 800;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic signed [15:0] goal_heading;
        logic signed [23:0] goal_y;
        logic signed [23:0] goal_x;
        logic signed [15:0] car_heading;
        logic signed [23:0] car_y;
        logic signed [23:0] car_x;
    } pose_t;

    typedef struct {
        op_t   op;
        pose_t pose;
        bit    has_known;
        logic signed [15:0] known_steer;
        logic signed [15:0] known_err;
    } row_t;

    typedef struct packed {
        logic signed [15:0] heading_error;
        logic signed [15:0] steering;
    } steer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    pose_heading_pid_steering uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor copy of registers and controller state.
    longint kp, ki, kd, weight, near_d, total_cap, steer_cap;
    longint prev_err, err_sum;

    steer_t expected_steer[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;
    bit hold_receiver = 1'b0;
    int op_seen[4] = '{0, 0, 0, 0};

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint bound(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint bearing_q13(longint dy, longint dx);
        longint x, y, z, xn, yn;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 65536;
        y = dy * 65536;
        if (x < 0) begin
            z = (y >= 0) ? 3294199 : -3294199;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                xn = x + asr(y, i);
                yn = y - asr(x, i);
                z += longint'(atan_q20(5'(i)));
            end else begin
                xn = x - asr(y, i);
                yn = y + asr(x, i);
                z -= longint'(atan_q20(5'(i)));
            end
            x = xn;
            y = yn;
        end
        return bound(asr(z + 64, 7), -25736, 25736);
    endfunction

    // Applies one item to the predicted state and returns its result.
    function automatic steer_t predict_steering(op_t op, pose_t p);
        steer_t r;
        longint dx, dy, brg, err, diff, acc, ctrl, w;
        dx = longint'(p.goal_x) - longint'(p.car_x);
        dy = longint'(p.goal_y) - longint'(p.car_y);
        if (op == OP_CLR) begin
            prev_err = 0;
            err_sum = 0;
            return '0;
        end
        if (op == OP_TRAJ) begin
            brg = bearing_q13(dy, dx);
            if (dx * dx + dy * dy <= near_d * near_d) begin
                w = weight > 4096 ? 4096 : weight;
                brg = asr(w * brg + (4096 - w) * longint'(p.goal_heading) + 2048, 12);
            end
        end else if (op == OP_REV) begin
            brg = bearing_q13(-dy, -dx);
        end else begin
            brg = bearing_q13(dy, dx);
        end
        err = brg - longint'(p.car_heading);
        if (err < -25736) err += 51472;
        else if (err > 25736) err -= 51472;
        err = bound(err, -32768, 32767);
        diff = err - prev_err;
        prev_err = err;
        err_sum += err;
        if (op == OP_TRAJ) err_sum = bound(err_sum, -total_cap, total_cap);
        else err_sum = bound(err_sum, -8388608, 8388607);
        acc = kp * err + ki * err_sum + kd * diff;
        ctrl = bound(asr(acc + 2048, 12), -steer_cap, steer_cap);
        if (op == OP_REV) ctrl = -ctrl;
        r.steering = 16'(ctrl);
        r.heading_error = 16'(err);
        return r;
    endfunction

    // Writes one register; the caller drops cfg_we after its last write.
    task automatic write_reg(cfg_idx_t idx, longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        case (idx)
            CFG_GAIN_P: kp = longint'($signed(16'(value)));
            CFG_GAIN_I: ki = longint'($signed(16'(value)));
            CFG_GAIN_D: kd = longint'($signed(16'(value)));
            CFG_GOAL_WEIGHT: weight = value & 13'h1fff;
            CFG_NEAR_DIST: near_d = value & 23'h7fffff;
            CFG_SUM_LIMIT: total_cap = value & 23'h7fffff;
            CFG_OUT_LIMIT: steer_cap = value & 15'h7fff;
            default: ;
        endcase
    endtask

    // Waits for every result, then lets the block's pipeline drain fully.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_steer.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sends one item with an optional random gap before it. The valid stays
    // high after the accepting edge until the next item or a gap replaces it.
    task automatic send_item(op_t op, pose_t p);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {16'b0, p};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_steer.push_back(predict_steering(op, p));
        op_seen[op]++;
        items_sent++;
    endtask

    function automatic pose_t random_pose(bit nearby);
        pose_t p;
        p.car_x = 24'($urandom);
        p.car_y = 24'($urandom);
        p.car_heading = 16'($signed($urandom_range(0, 51472)) - 25736);
        p.goal_heading = 16'($signed($urandom_range(0, 51472)) - 25736);
        case ($urandom_range(0, 3))
            0: begin
                p.goal_x = 24'($urandom);
                p.goal_y = 24'($urandom);
            end
            1: begin
                p.goal_x = p.car_x;
                p.goal_y = p.car_y;
            end
            default: begin
                p.car_x = 24'($signed($urandom_range(0, 8000000)) - 4000000);
                p.car_y = 24'($signed($urandom_range(0, 8000000)) - 4000000);
                p.goal_x = p.car_x + 24'($signed($urandom_range(0, 20000)) - 10000);
                p.goal_y = p.car_y + 24'($signed($urandom_range(0, 20000)) - 10000);
            end
        endcase
        if (nearby) begin
            p.goal_x = p.car_x + 24'($signed($urandom_range(0, 4000)) - 2000);
            p.goal_y = p.car_y + 24'($signed($urandom_range(0, 4000)) - 2000);
        end
        return p;
    endfunction

    // Directed table: extremes, every operation, zero offset, wrap cases.
    // Rows with has_known carry a known result that the prediction must match.
    row_t directed[$];

    task automatic add_row(op_t op, logic signed [23:0] cx, logic signed [23:0] cy,
                           logic signed [15:0] ch, logic signed [23:0] gx,
                           logic signed [23:0] gy, logic signed [15:0] gh,
                           bit known, logic signed [15:0] ks, logic signed [15:0] ke);
        row_t r;
        r.op = op;
        r.pose = '{gh, gy, gx, ch, cy, cx};
        r.has_known = known;
        r.known_steer = ks;
        r.known_err = ke;
        directed.push_back(r);
    endtask

    // Receiver: random stalls, one long hold-off that fills the block.
    initial begin
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_receiver || (!quiet_phase && $urandom_range(0, 5) == 0)) begin
                m_tready <= 1'b0;
                if (!hold_receiver)
                    repeat ($urandom_range(1, 9) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        steer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (expected_steer.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_steer.pop_front();
                if (got.steering !== want.steering) begin
                    $display("%0t: steering expected %0d actual %0d", $time,
                             want.steering, got.steering);
                    errors++;
                end
                if (got.heading_error !== want.heading_error) begin
                    $display("%0t: heading_error expected %0d actual %0d", $time,
                             want.heading_error, got.heading_error);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        longint gains[4];
        kp = 3277; ki = 0; kd = -1434; weight = 4096;
        near_d = 4915; total_cap = 81920; steer_cap = 6554;
        prev_err = 0; err_sum = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default gains: a goal straight ahead gives zero error and steering.
        add_row(OP_FWD, 0, 0, 0, 4096, 0, 0, 1, 16'sd0, 16'sd0);
        add_row(OP_FWD, 0, 0, 0, 0, 4096, 0, 0, 0, 0);
        add_row(OP_REV, 0, 0, 0, -4096, 0, 0, 0, 0, 0);
        add_row(OP_FWD, 0, 0, 25736, 0, 0, 0, 0, 0, 0);      // zero offset
        add_row(OP_FWD, -8388608, -8388608, -25736, 8388607, 8388607, 0, 0, 0, 0);
        add_row(OP_REV, 8388607, 8388607, 25736, -8388608, -8388608, 0, 0, 0, 0);
        add_row(OP_FWD, 0, 0, -25736, -4096, 1, 0, 0, 0, 0);  // wrap above pi
        add_row(OP_FWD, 0, 0, 25736, -4096, -1, 0, 0, 0, 0);  // wrap below -pi
        add_row(OP_FWD, 0, 0, 0, -4096, 0, 0, 0, 0, 0);
        add_row(OP_TRAJ, 0, 0, 0, 100, 100, 25736, 0, 0, 0);  // near: blended
        add_row(OP_TRAJ, 0, 0, 0, 4915, 0, -25736, 0, 0, 0);
        add_row(OP_TRAJ, 0, 0, 100, 800000, -900000, 0, 0, 0, 0);
        add_row(OP_TRAJ, 0, 0, -25736, 0, 0, 25736, 0, 0, 0);
        add_row(OP_CLR, 8388607, -8388608, -1, 8388607, -1, -1, 1, 16'sd0, 16'sd0);
        add_row(OP_REV, 5, 7, -100, 5, 7, 0, 0, 0, 0);
        add_row(OP_FWD, -1, -1, -1, -1, -1, -1, 0, 0, 0);
        add_row(OP_CLR, 0, 0, 0, 0, 0, 0, 1, 16'sd0, 16'sd0);

        for (int i = 0; i < directed.size(); i++) begin
            if (directed[i].has_known) begin
                drain();
                send_item(directed[i].op, directed[i].pose);
                if (expected_steer[$].steering !== directed[i].known_steer ||
                    expected_steer[$].heading_error !== directed[i].known_err) begin
                    $display("%0t: row %0d expected %0d/%0d actual prediction %0d/%0d",
                             $time, i, directed[i].known_steer, directed[i].known_err,
                             expected_steer[$].steering, expected_steer[$].heading_error);
                    errors++;
                end
            end else begin
                send_item(directed[i].op, directed[i].pose);
            end
        end

        // Several register settings, extremes among them; each phase sends random items.
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: gains = '{32767, 32767, 32767, 0};
                1: gains = '{-32768, -32768, -32768, 4096};
                2: gains = '{3277, 400, -1434, 8191};
                3: gains = '{-5000, 12000, 700, 2048};
                default: gains = '{longint'($urandom_range(0, 65535)),
                                   longint'($urandom_range(0, 65535)),
                                   longint'($urandom_range(0, 65535)),
                                   longint'($urandom_range(0, 8191))};
            endcase
            write_reg(CFG_GAIN_P, gains[0]);
            write_reg(CFG_GAIN_I, gains[1]);
            write_reg(CFG_GAIN_D, gains[2]);
            write_reg(CFG_GOAL_WEIGHT, gains[3]);
            write_reg(CFG_NEAR_DIST, phase == 0 ? 0 : (phase == 1 ? 8388607 :
                      longint'($urandom_range(0, 8000))));
            write_reg(CFG_SUM_LIMIT, phase == 0 ? 0 : (phase == 1 ? 8388607 :
                      longint'($urandom_range(0, 200000))));
            write_reg(CFG_OUT_LIMIT, phase == 0 ? 32767 : (phase == 1 ? 0 :
                      longint'($urandom_range(0, 25736))));
            cfg_we <= 1'b0;
            if (phase == 7) quiet_phase = 1'b1;
            for (int k = 0; k < ITEM_COUNT / 8; k++) begin
                op_t op;
                op = op_t'($urandom_range(0, 15) == 0 ? OP_CLR : $urandom_range(0, 2));
                if (phase == 3 && k == 10) begin
                    // Receiver holds off while the sender keeps offering items.
                    fork
                        begin
                            hold_receiver = 1'b1;
                            repeat (300) @(posedge aclk);
                            hold_receiver = 1'b0;
                        end
                    join_none
                end
                send_item(op, random_pose(op == OP_TRAJ && $urandom_range(0, 1)));
            end
        end

        drain();
        $display("Covered %0d items (fwd %0d, rev %0d, traj %0d, clear %0d) over 8 settings;",
                 items_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("checked %0d results with %0d mismatches.", results_seen, errors);
        if (errors == 0 && expected_steer.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
